FILE: hw/rtl/imucf_pkg.sv
// Shared types, constants and helper functions of the IMU complementary filter.
// No dependencies; used by imucf_front, imucf_back, imu_complementary_filter_core and the verif files.
package imucf_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int ITER_W       = 5;
  localparam int IN_SHIFT     = 12;
  localparam int DIV_BITS     = 48;
  localparam int ROOT_BITS    = 28;
  localparam int CNT_W        = 6;
  localparam int CFG_IDX_W    = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_WEIGHT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_LSB    = 8'd1;

  localparam logic signed [31:0] QUARTER_TURN = 32'sd5898240;  // 90 deg in Q16

  typedef struct packed {
    logic [16:0] gyro_weight;
    logic [15:0] gyro_lsb;
  } cfg_t;

  // Item after the front end: squares summed, gyro magnitudes times dt split from sign.
  typedef struct packed {
    logic [31:0]        sumsq;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [30:0]        gx_mag;
    logic [30:0]        gy_mag;
    logic [30:0]        gz_mag;
    logic               gx_neg;
    logic               gy_neg;
    logic               gz_neg;
  } item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT_DIV,
    ST_CORDIC,
    ST_MUL,
    ST_SUM
  } back_state_e;

  // Turn a vector in the left half plane into the right half plane.
  function automatic vec_t prerotate(input logic signed [31:0] x, input logic signed [31:0] y);
    vec_t v;
    v.x = x;
    v.y = y;
    v.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        v.x = y;
        v.y = -x;
        v.z = QUARTER_TURN;
      end else begin
        v.x = -y;
        v.y = x;
        v.z = -QUARTER_TURN;
      end
    end
    return v;
  endfunction

  // atan(2^-i) in Q16 degrees.
  function automatic logic signed [31:0] atan_q16(input logic [ITER_W-1:0] i);
    logic signed [31:0] a;
    unique case (i)
      5'd0:  a = 32'sd2949120;
      5'd1:  a = 32'sd1740967;
      5'd2:  a = 32'sd919879;
      5'd3:  a = 32'sd466945;
      5'd4:  a = 32'sd234379;
      5'd5:  a = 32'sd117304;
      5'd6:  a = 32'sd58666;
      5'd7:  a = 32'sd29335;
      5'd8:  a = 32'sd14668;
      5'd9:  a = 32'sd7334;
      5'd10: a = 32'sd3667;
      5'd11: a = 32'sd1833;
      5'd12: a = 32'sd917;
      5'd13: a = 32'sd458;
      5'd14: a = 32'sd229;
      5'd15: a = 32'sd115;
      5'd16: a = 32'sd57;
      5'd17: a = 32'sd29;
      5'd18: a = 32'sd14;
      5'd19: a = 32'sd7;
      5'd20: a = 32'sd4;
      5'd21: a = 32'sd2;
      5'd22: a = 32'sd1;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

endpackage

FILE: hw/rtl/imucf_front.sv
// Front end: accepts samples, forms squares and gyro-times-dt magnitudes,
// and holds them in a two-entry queue. Depends on imucf_pkg.
module imucf_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic signed [15:0]     accel_x_i,
  input  logic signed [15:0]     accel_y_i,
  input  logic signed [15:0]     accel_z_i,
  input  logic signed [15:0]     gyro_x_i,
  input  logic signed [15:0]     gyro_y_i,
  input  logic signed [15:0]     gyro_z_i,
  input  logic [15:0]            elapsed_ms_i,
  output imucf_pkg::item_t       item_o,
  output logic                   item_valid_o,
  input  logic                   item_take_i
);
  import imucf_pkg::*;

  item_t       mem [2];
  item_t       item_d;
  logic        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push_ok, take_ok;
  logic signed [31:0] sq_y, sq_z;
  logic [15:0] gx_abs, gy_abs, gz_abs;

  assign full         = (count_q == 2'd2);
  assign item_valid_o = (count_q != 2'd0);
  assign push_ok      = push && !full;
  assign take_ok      = item_take_i && item_valid_o;
  assign item_o       = mem[rd_ptr_q];

  always_comb begin
    sq_y   = accel_y_i * accel_y_i;
    sq_z   = accel_z_i * accel_z_i;
    gx_abs = gyro_x_i[15] ? 16'(-gyro_x_i) : 16'(gyro_x_i);
    gy_abs = gyro_y_i[15] ? 16'(-gyro_y_i) : 16'(gyro_y_i);
    gz_abs = gyro_z_i[15] ? 16'(-gyro_z_i) : 16'(gyro_z_i);
    item_d.sumsq  = 32'(sq_y) + 32'(sq_z);
    item_d.ax     = accel_x_i;
    item_d.ay     = accel_y_i;
    item_d.az     = accel_z_i;
    item_d.gx_mag = 31'(gx_abs * elapsed_ms_i);
    item_d.gy_mag = 31'(gy_abs * elapsed_ms_i);
    item_d.gz_mag = 31'(gz_abs * elapsed_ms_i);
    item_d.gx_neg = gyro_x_i[15];
    item_d.gy_neg = gyro_y_i[15];
    item_d.gz_neg = gyro_z_i[15];
  end

  always_comb begin
    wr_ptr_d = push_ok ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = take_ok ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_ok) - 2'(take_ok);
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[wr_ptr_q] <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");
  a_full_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full && !item_take_i) |=> full) else $error("full queue lost an entry");
  a_take_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_ok && !push_ok) |=> (count_q == $past(count_q) - 2'd1))
    else $error("take did not drop an entry");

endmodule

FILE: hw/rtl/imucf_back.sv
// Back end: square root, gyro rate division, CORDIC and blend for one item
// at a time, plus the result register. Depends on imucf_pkg.
module imucf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  imucf_pkg::cfg_t    cfg_i,
  input  imucf_pkg::item_t   item_i,
  input  logic               item_valid_i,
  output logic               item_take_o,
  output logic               out_valid_o,
  input  logic               pop_i,
  output logic signed [31:0] roll_o,
  output logic signed [31:0] pitch_o,
  output logic signed [31:0] yaw_o
);
  import imucf_pkg::*;

  back_state_e state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [55:0]       rv_q, rv_d;
  logic [31:0]       rrem_q, rrem_d;
  logic [ROOT_BITS-1:0] root_q, root_d;
  logic [25:0]       den_q, den_d;
  logic [DIV_BITS-1:0] n_q [3];
  logic [DIV_BITS-1:0] n_d [3];
  logic [DIV_BITS-1:0] quo_q [3];
  logic [DIV_BITS-1:0] quo_d [3];
  logic [25:0]       drem_q [3];
  logic [25:0]       drem_d [3];
  logic [2:0]        neg_q, neg_d;
  logic signed [15:0] ax_q, ay_q, az_q;
  vec_t              cv_q, cv_d, cstep, roll_init, pitch_init;
  logic [ITER_W-1:0] it_q, it_d;
  logic              sel_q, sel_d, zero_q, zero_d;
  logic signed [31:0] acc_roll_q, acc_roll_d, acc_pitch_q, acc_pitch_d;
  logic signed [31:0] roll_q, roll_d, pitch_q, pitch_d, yaw_q, yaw_d;
  logic signed [59:0] pwr_q, pwp_q;
  logic signed [49:0] par_q, pap_q;
  logic              out_valid_q, out_valid_d;

  logic        take, out_write, root_step, div_run, cord_last;
  logic [16:0] w_eff, aw;
  logic [15:0] lsb_eff;
  logic [25:0] den_new;
  logic signed [41:0] inc_x, inc_y, inc_z, sum_r, sum_p;
  logic signed [31:0] xs, ys;
  logic [31:0] rs, trial;
  logic [26:0] r2 [3];
  logic signed [60:0] s_r, s_p;
  logic signed [44:0] sh_r, sh_p;

  // Clamp configuration.
  always_comb begin
    w_eff   = (cfg_i.gyro_weight > 17'd65536) ? 17'd65536 : cfg_i.gyro_weight;
    aw      = 17'd65536 - w_eff;
    lsb_eff = (cfg_i.gyro_lsb == 16'd0) ? 16'd1 : cfg_i.gyro_lsb;
    den_new = 26'(lsb_eff) * 26'd1000;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (item_valid_i) state_d = ST_ROOT_DIV;
      ST_ROOT_DIV: if (cnt_q == CNT_W'(DIV_BITS - 1)) state_d = ST_CORDIC;
      ST_CORDIC:   if (sel_q && cord_last) state_d = ST_MUL;
      ST_MUL:      state_d = ST_SUM;
      ST_SUM:      if (!out_valid_q || pop_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Control strobes.
  always_comb begin
    take      = 1'b0;
    div_run   = 1'b0;
    out_write = 1'b0;
    unique case (state_q)
      ST_IDLE:     take = item_valid_i;
      ST_ROOT_DIV: div_run = 1'b1;
      ST_SUM:      out_write = !out_valid_q || pop_i;
      default:     ;
    endcase
    root_step = div_run && (cnt_q < CNT_W'(ROOT_BITS));
    cord_last = (it_q == ITER_W'(CORDIC_ITERS - 1));
  end
  assign item_take_o = take;

  // Signed gyro increments from the quotients.
  always_comb begin
    inc_x = neg_q[0] ? -$signed({1'b0, quo_q[0][40:0]}) : $signed({1'b0, quo_q[0][40:0]});
    inc_y = neg_q[1] ? -$signed({1'b0, quo_q[1][40:0]}) : $signed({1'b0, quo_q[1][40:0]});
    inc_z = neg_q[2] ? -$signed({1'b0, quo_q[2][40:0]}) : $signed({1'b0, quo_q[2][40:0]});
    sum_r = 42'(roll_q) + inc_x;
    sum_p = 42'(pitch_q) + inc_y;
  end

  // CORDIC step and vector setup.
  always_comb begin
    roll_init  = prerotate({{4{az_q[15]}}, az_q, 12'b0}, {{4{ay_q[15]}}, ay_q, 12'b0});
    pitch_init = prerotate({4'b0, root_q}, -{{4{ax_q[15]}}, ax_q, 12'b0});
    xs = cv_q.x >>> it_q;
    ys = cv_q.y >>> it_q;
    if (!cv_q.y[31]) begin
      cstep.x = cv_q.x + ys;
      cstep.y = cv_q.y - xs;
      cstep.z = cv_q.z + atan_q16(it_q);
    end else begin
      cstep.x = cv_q.x - ys;
      cstep.y = cv_q.y + xs;
      cstep.z = cv_q.z - atan_q16(it_q);
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    rv_d   = rv_q;
    rrem_d = rrem_q;
    root_d = root_q;
    den_d  = den_q;
    neg_d  = neg_q;
    n_d    = n_q;
    quo_d  = quo_q;
    drem_d = drem_q;
    cv_d   = cv_q;
    it_d   = it_q;
    sel_d  = sel_q;
    zero_d = zero_q;
    acc_roll_d  = acc_roll_q;
    acc_pitch_d = acc_pitch_q;
    roll_d  = roll_q;
    pitch_d = pitch_q;
    yaw_d   = yaw_q;
    out_valid_d = out_valid_q && !pop_i;
    rs    = {rrem_q[29:0], rv_q[55:54]};
    trial = {2'b0, root_q, 2'b01};
    for (int k = 0; k < 3; k++) begin
      r2[k] = {drem_q[k], n_q[k][DIV_BITS-1]};
    end

    if (take) begin
      cnt_d  = '0;
      rv_d   = {item_i.sumsq, 24'b0};
      rrem_d = '0;
      root_d = '0;
      den_d  = den_new;
      neg_d  = {item_i.gz_neg, item_i.gy_neg, item_i.gx_neg};
      n_d[0] = DIV_BITS'({item_i.gx_mag, 16'b0}) + DIV_BITS'(den_new >> 1);
      n_d[1] = DIV_BITS'({item_i.gy_mag, 16'b0}) + DIV_BITS'(den_new >> 1);
      n_d[2] = DIV_BITS'({item_i.gz_mag, 16'b0}) + DIV_BITS'(den_new >> 1);
      for (int k = 0; k < 3; k++) begin
        quo_d[k]  = '0;
        drem_d[k] = '0;
      end
    end

    if (div_run) begin
      cnt_d = cnt_q + CNT_W'(1);
      for (int k = 0; k < 3; k++) begin
        n_d[k] = {n_q[k][DIV_BITS-2:0], 1'b0};
        if (r2[k] >= {1'b0, den_q}) begin
          drem_d[k] = 26'(r2[k] - {1'b0, den_q});
          quo_d[k]  = {quo_q[k][DIV_BITS-2:0], 1'b1};
        end else begin
          drem_d[k] = r2[k][25:0];
          quo_d[k]  = {quo_q[k][DIV_BITS-2:0], 1'b0};
        end
      end
      if (cnt_q == CNT_W'(DIV_BITS - 1)) begin
        cv_d   = roll_init;
        it_d   = '0;
        sel_d  = 1'b0;
        zero_d = (ay_q == 16'sd0) && (az_q == 16'sd0);
      end
    end

    if (root_step) begin
      rv_d = {rv_q[53:0], 2'b00};
      if (rs >= trial) begin
        rrem_d = rs - trial;
        root_d = {root_q[ROOT_BITS-2:0], 1'b1};
      end else begin
        rrem_d = rs;
        root_d = {root_q[ROOT_BITS-2:0], 1'b0};
      end
    end

    if (state_q == ST_CORDIC) begin
      cv_d = cstep;
      it_d = it_q + ITER_W'(1);
      if (cord_last) begin
        if (!sel_q) begin
          acc_roll_d = zero_q ? 32'sd0 : cstep.z;
          cv_d   = pitch_init;
          it_d   = '0;
          sel_d  = 1'b1;
          zero_d = (ax_q == 16'sd0) && (root_q == '0);
        end else begin
          acc_pitch_d = zero_q ? 32'sd0 : cstep.z;
        end
      end
    end

    s_r  = 61'(pwr_q) + 61'(par_q) + 61'sd32768;
    s_p  = 61'(pwp_q) + 61'(pap_q) + 61'sd32768;
    sh_r = 45'(s_r >>> 16);
    sh_p = 45'(s_p >>> 16);
    if (out_write) begin
      roll_d  = (sh_r > 45'sd2147483647) ? 32'sh7fffffff :
                (sh_r < -45'sd2147483648) ? 32'sh80000000 : 32'(sh_r);
      pitch_d = (sh_p > 45'sd2147483647) ? 32'sh7fffffff :
                (sh_p < -45'sd2147483648) ? 32'sh80000000 : 32'(sh_p);
      yaw_d   = yaw_q + 32'(inc_z);
      out_valid_d = 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rv_q   <= rv_d;
    rrem_q <= rrem_d;
    root_q <= root_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    n_q    <= n_d;
    quo_q  <= quo_d;
    drem_q <= drem_d;
    cv_q   <= cv_d;
    it_q   <= it_d;
    sel_q  <= sel_d;
    zero_q <= zero_d;
    acc_roll_q  <= acc_roll_d;
    acc_pitch_q <= acc_pitch_d;
    if (take) begin
      ax_q <= item_i.ax;
      ay_q <= item_i.ay;
      az_q <= item_i.az;
    end
    if (state_q == ST_MUL) begin
      pwr_q <= $signed({1'b0, w_eff}) * sum_r;
      pwp_q <= $signed({1'b0, w_eff}) * sum_p;
      par_q <= $signed({1'b0, aw}) * acc_roll_q;
      pap_q <= $signed({1'b0, aw}) * acc_pitch_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      roll_q      <= '0;
      pitch_q     <= '0;
      yaw_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      roll_q      <= roll_d;
      pitch_q     <= pitch_d;
      yaw_q       <= yaw_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign roll_o      = roll_q;
  assign pitch_o     = pitch_q;
  assign yaw_o       = yaw_q;

  a_div_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT_DIV) |-> (cnt_q < CNT_W'(DIV_BITS))) else $error("divider overrun");
  a_result_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop_i) |=> ($stable(yaw_q) && $stable(roll_q)))
    else $error("waiting result changed");
  a_take_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (state_q == ST_ROOT_DIV && cnt_q == '0)) else $error("item start lost");

endmodule

FILE: hw/rtl/imu_complementary_filter_core.sv
// Top level of the IMU complementary filter: configuration registers, front
// queue and back end. Depends on imucf_pkg, imucf_front and imucf_back.
//
// Channel   Direction  Handshake             Payload
// input     in         push / full           accel_x/y/z, gyro_x/y/z, elapsed_ms
// result    out        empty / pop           roll_out, pitch_out, yaw_out
// config    in         cfg_valid / ready     cfg_index, cfg_data
//
// In the back end a sample runs through a take step, the shared restoring divider
// loop for the 48-bit quotients (the square root completes within it), then
// 2 x 16 CORDIC iterations on one shift-add unit, a multiply step and a blend step.
// The front queue holds two samples, so push sees full only when two wait.
// A finished result waits in the output register while the next sample runs.
// Reset clears the angles, the queues and loads the default weight and scale.
module imu_complementary_filter_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] gyro_x_i,
  input  logic signed [15:0] gyro_y_i,
  input  logic signed [15:0] gyro_z_i,
  input  logic [15:0]        elapsed_ms_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] roll_out_o,
  output logic signed [31:0] pitch_out_o,
  output logic signed [31:0] yaw_out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [imucf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [16:0]        cfg_data_i
);
  import imucf_pkg::*;

  cfg_t   cfg_q, cfg_d;
  item_t  item;
  logic   item_valid, item_take, out_valid;

  // Config writes are always accepted (ready is tied high); unknown indexes drop.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_GYRO_WEIGHT) begin
        cfg_d.gyro_weight = cfg_data_i;
      end else if (cfg_index_i == CFG_GYRO_LSB) begin
        cfg_d.gyro_lsb = cfg_data_i[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gyro_weight <= 17'd62915;
      cfg_q.gyro_lsb    <= 16'd131;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Accept samples and form their squares and gyro magnitudes.
  imucf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .accel_x_i    (accel_x_i),
    .accel_y_i    (accel_y_i),
    .accel_z_i    (accel_z_i),
    .gyro_x_i     (gyro_x_i),
    .gyro_y_i     (gyro_y_i),
    .gyro_z_i     (gyro_z_i),
    .elapsed_ms_i (elapsed_ms_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_take_i  (item_take)
  );

  // Compute and hold the result until it is transferred out.
  imucf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_take_o  (item_take),
    .out_valid_o  (out_valid),
    .pop_i        (pop),
    .roll_o       (roll_out_o),
    .pitch_o      (pitch_out_o),
    .yaw_o        (yaw_out_o)
  );

  assign empty = !out_valid;

endmodule

FILE: verif/imucf_checker.sv
`timescale 1ns / 1ps
// Checker for imu_complementary_filter_core: watches the sample, result and register channels,
// predicts every result from its own copy of the filter state and compares. Depends on imucf_pkg.
module imucf_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  logic                            full_i,
  input  logic signed [15:0]              accel_x_i,
  input  logic signed [15:0]              accel_y_i,
  input  logic signed [15:0]              accel_z_i,
  input  logic signed [15:0]              gyro_x_i,
  input  logic signed [15:0]              gyro_y_i,
  input  logic signed [15:0]              gyro_z_i,
  input  logic [15:0]                     elapsed_ms_i,
  input  logic                            empty_i,
  input  logic                            pop_i,
  input  logic signed [31:0]              roll_i,
  input  logic signed [31:0]              pitch_i,
  input  logic signed [31:0]              yaw_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [imucf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [16:0]                     cfg_data_i,
  output int                              mismatch_count_o,
  output int                              pending_o
);
  typedef struct {
    logic signed [31:0] roll;
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
  } attitude_t;

  localparam longint ARCTAN_Q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  attitude_t          attitude_q[$];
  logic signed [31:0] roll_st, pitch_st, yaw_st;
  logic [16:0]        weight_reg;
  logic [15:0]        scale_reg;

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // Vectoring-mode CORDIC angle in Q16 degrees.
  function automatic longint heading_q16(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = 90 * 65536;
      end else begin
        x = -y;
        y = t;
        z = -90 * 65536;
      end
    end
    for (int i = 0; i < imucf_pkg::CORDIC_ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN_Q16[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN_Q16[i];
      end
    end
    return z;
  endfunction

  // Angle step in Q16 degrees, rounded half away from zero.
  function automatic longint rate_step(longint g, longint ms, longint lsb);
    longint num, den, mag, q;
    num = g * ms * 65536;
    den = lsb * 1000;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [31:0] mix_angle(logic signed [31:0] angle, longint inc,
                                                   longint acc, longint w);
    longint a, s;
    a = angle;
    s = (w * (a + inc) + (65536 - w) * acc + 32768) >>> 16;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  assign pending_o = attitude_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    longint    ax, ay, az, w, lsb, den, acc_roll, acc_pitch;
    attitude_t want;
    if (!rst_ni) begin
      roll_st          <= '0;
      pitch_st         <= '0;
      yaw_st           <= '0;
      weight_reg       <= 17'd62915;
      scale_reg        <= 16'd131;
      mismatch_count_o <= 0;
      attitude_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          imucf_pkg::CFG_GYRO_WEIGHT: weight_reg <= cfg_data_i;
          imucf_pkg::CFG_GYRO_LSB:    scale_reg  <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (push_i && !full_i) begin
        ax = accel_x_i;
        ay = accel_y_i;
        az = accel_z_i;
        w = (weight_reg > 17'd65536) ? 65536 : longint'(weight_reg);
        lsb = (scale_reg == 0) ? 1 : longint'(scale_reg);
        den = root_floor(longint'((ay * ay + az * az) * 64'd16777216));
        acc_roll = heading_q16(ay * 4096, az * 4096);
        acc_pitch = heading_q16(-ax * 4096, den);
        want.roll = mix_angle(roll_st, rate_step(gyro_x_i, elapsed_ms_i, lsb), acc_roll, w);
        want.pitch = mix_angle(pitch_st, rate_step(gyro_y_i, elapsed_ms_i, lsb), acc_pitch, w);
        want.yaw = yaw_st + rate_step(gyro_z_i, elapsed_ms_i, lsb);
        roll_st  <= want.roll;
        pitch_st <= want.pitch;
        yaw_st   <= want.yaw;
        attitude_q.push_back(want);
      end
      if (pop_i && !empty_i) begin
        if (attitude_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected: roll %0d pitch %0d yaw %0d",
                   $time, roll_i, pitch_i, yaw_i);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          want = attitude_q.pop_front();
          if (roll_i !== want.roll || pitch_i !== want.pitch || yaw_i !== want.yaw) begin
            $display("%0t: mismatch expected roll %0d pitch %0d yaw %0d, got %0d %0d %0d",
                     $time, want.roll, want.pitch, want.yaw, roll_i, pitch_i, yaw_i);
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
    end
  end
endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Top of the imu_complementary_filter_core regression: clock, reset, stimulus, verdict.
// Depends on imucf_pkg, imu_complementary_filter_core and imucf_checker.
module testbench;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic        full, empty, cfg_ready_o;
  logic signed [15:0] accel_x_i = '0, accel_y_i = '0, accel_z_i = '0;
  logic signed [15:0] gyro_x_i = '0, gyro_y_i = '0, gyro_z_i = '0;
  logic [15:0] elapsed_ms_i = '0;
  logic signed [31:0] roll_out_o, pitch_out_o, yaw_out_o;
  logic        cfg_valid_i = 1'b0;
  logic [imucf_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [16:0] cfg_data_i = '0;

  int mismatch_count, pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int idle_cycles = 0;
  int samples_sent = 0;
  int reg_writes = 0;

  always #2 clk_i = ~clk_i;

  imu_complementary_filter_core u_dut (
    .clk_i, .rst_ni, .push, .full,
    .accel_x_i, .accel_y_i, .accel_z_i, .gyro_x_i, .gyro_y_i, .gyro_z_i, .elapsed_ms_i,
    .empty, .pop, .roll_out_o, .pitch_out_o, .yaw_out_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  imucf_checker u_checker (
    .clk_i, .rst_ni, .push_i(push), .full_i(full),
    .accel_x_i, .accel_y_i, .accel_z_i, .gyro_x_i, .gyro_y_i, .gyro_z_i, .elapsed_ms_i,
    .empty_i(empty), .pop_i(pop), .roll_i(roll_out_o), .pitch_i(pitch_out_o),
    .yaw_i(yaw_out_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .mismatch_count_o(mismatch_count), .pending_o(pending)
  );

  // Receiver side: stall pop at the rate of the current phase.
  always @(negedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: count cycles in which no channel completes a transfer.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results still expected", $time, pending);
        $display("imu_complementary_filter_core regression: fail");
        $finish;
      end
    end
  end

  // Offer one sample; returns at the falling edge after its transfer.
  task automatic send_sample(input logic [15:0] ax, ay, az, gx, gy, gz, ms);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push         <= 1'b1;
    accel_x_i    <= ax;
    accel_y_i    <= ay;
    accel_z_i    <= az;
    gyro_x_i     <= gx;
    gyro_y_i     <= gy;
    gyro_z_i     <= gz;
    elapsed_ms_i <= ms;
    #1;
    while (full) begin
      @(negedge clk_i);
      #1;
    end
    @(negedge clk_i);
    samples_sent++;
  endtask

  // Write one register; returns at the falling edge after valid drops.
  task automatic write_reg(input logic [imucf_pkg::CFG_IDX_W-1:0] idx, input logic [16:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    #1;
    while (!cfg_ready_o) begin
      @(negedge clk_i);
      #1;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    reg_writes++;
  endtask

  // Hold until every expected result has been popped.
  task automatic drain();
    push <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // Mostly a sensor at rest or in slow motion, some full-range noise.
  task automatic random_sample();
    logic [15:0] f [7];
    if ($urandom_range(99) < 60) begin
      f[0] = 16'($signed($urandom_range(8000)) - 4000);
      f[1] = 16'($signed($urandom_range(8000)) - 4000);
      f[2] = 16'($signed($urandom_range(6000)) + 13000);
      if ($urandom_range(3) == 0) f[2] = -f[2];
      for (int k = 3; k < 6; k++) f[k] = 16'($signed($urandom_range(4000)) - 2000);
      f[6] = 16'($urandom_range(40));
    end else begin
      for (int k = 0; k < 7; k++) f[k] = 16'($urandom);
    end
    send_sample(f[0], f[1], f[2], f[3], f[4], f[5], f[6]);
  endtask

  initial begin
    static logic [16:0] weight_set [6] =
      '{17'd62915, 17'd65536, 17'd0, 17'd131071, 17'd32768, 17'd1};
    static logic [16:0] scale_set  [6] =
      '{17'd131, 17'd1, 17'd65535, 17'd0, 17'd1000, 17'd16};

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: zero vector, axis extremes, both left-half-plane turns, time step extremes.
    send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0);
    send_sample(16'sd0, 16'sd0, 16'sd16384, 16'sd131, 16'sd131, 16'sd131, 16'd10);
    send_sample(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'd65535);
    send_sample(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                16'd65535);
    send_sample(16'sd100, 16'sd2000, -16'sd16000, -16'sd500, 16'sd500, 16'sd0, 16'd1);
    send_sample(-16'sd100, -16'sd2000, -16'sd16000, 16'sd500, -16'sd500, 16'sd0, 16'd1);
    send_sample(16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd1, 16'd1);
    send_sample(-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'd1);
    send_sample(16'sd32767, 16'sd0, 16'sd0, 16'sd65, 16'sd66, -16'sd65, 16'd1);
    send_sample(16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd65535);
    send_sample(16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0);
    send_sample(16'sd1, -16'sd1, -16'sd1, 16'sd32767, -16'sd32768, 16'sd32767, 16'd1000);
    drain();

    // Random phases: each with its own register setting and idling pattern.
    for (int p = 0; p < 6; p++) begin
      write_reg(imucf_pkg::CFG_GYRO_WEIGHT, weight_set[p]);
      write_reg(imucf_pkg::CFG_GYRO_LSB, scale_set[p]);
      write_reg(8'($urandom_range(255, 2)), 17'($urandom));  // unmapped, must be ignored
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      repeat (150) random_sample();
      drain();
    end
    idle_pct = 0;
    stall_pct = 0;

    // Give the back end one sample time to show any stray result.
    repeat (200) @(negedge clk_i);

    $display("Covered %0d samples and %0d register writes over six weight/scale settings,",
             samples_sent, reg_writes);
    $display("including clamped weight, zero divisor, saturation and yaw wrap.");
    if (mismatch_count == 0 && pending == 0) begin
      $display("imu_complementary_filter_core regression: pass");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatch_count, pending);
      $display("imu_complementary_filter_core regression: fail");
    end
    $finish;
  end
endmodule

FILE: imu_complementary_filter_core.f
hw/rtl/imucf_pkg.sv
hw/rtl/imucf_front.sv
hw/rtl/imucf_back.sv
hw/rtl/imu_complementary_filter_core.sv
verif/imucf_checker.sv
verif/testbench.sv
